FILE: rtl/spq_pkg.sv
// shared types and constants for the sorted-array priority queue
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH     = 64;
    localparam int KEY_W     = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    localparam logic signed [KEY_W-1:0] EMPTY_KEY = -1;
    localparam logic signed [KEY_W-1:0] ZERO_KEY  = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_PEEK   = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic signed [KEY_W-1:0] key;
    } t_cell_ctrl;

endpackage

FILE: rtl/sorted_array_priority_queue_top.sv
// min-priority queue built as a chain of sorted key cells
//
//  channel   dir  tdata               tuser
//  s_axis    in   value [31:0]        command [1:0]
//  m_axis    out  result_value [31:0] status [1:0]
//
// the chain compares the new key in all cells at once and shifts at the same
// edge, so one item per cycle is sustained while the result register drains
// results sit in one output register; input is taken while it is empty or
// being drained in the same cycle
// synchronous active-low reset empties the queue by clearing the valid bits
`timescale 1ns / 1ps

module sorted_array_priority_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] result_value
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int DEPTH = spq_pkg::DEPTH;
    localparam int KW    = spq_pkg::KEY_W;

    logic signed [KW-1:0] cell_key   [DEPTH];
    logic                 cell_valid [DEPTH];
    logic                 cell_take  [DEPTH];

    spq_pkg::t_cell_ctrl ctrl;
    spq_pkg::t_cmd       cmd;
    logic                accept;
    logic                full;
    logic                empty;

    logic                   r_m_valid;
    logic signed [KW-1:0]   r_m_key;
    spq_pkg::t_status       r_m_status;
    logic signed [KW-1:0]   n_m_key;
    spq_pkg::t_status       n_m_status;

    assign cmd    = spq_pkg::t_cmd'(s_axis_tuser);
    assign full   = cell_valid[DEPTH-1];
    assign empty  = !cell_valid[0];
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        ctrl.ins   = 1'b0;
        ctrl.del   = 1'b0;
        ctrl.key   = s_axis_tdata;
        n_m_key    = spq_pkg::ZERO_KEY;
        n_m_status = spq_pkg::ST_OK;
        case (cmd)
            spq_pkg::CMD_INSERT: begin
                if (full) begin
                    n_m_status = spq_pkg::ST_FULL;
                end else begin
                    ctrl.ins = accept;
                end
            end
            spq_pkg::CMD_DELETE, spq_pkg::CMD_PEEK: begin
                if (empty) begin
                    n_m_key    = spq_pkg::EMPTY_KEY;
                    n_m_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_m_key  = cell_key[0];
                    ctrl.del = accept && (cmd == spq_pkg::CMD_DELETE);
                end
            end
            default: begin
                // unused code: no change, zero result
                n_m_key    = spq_pkg::ZERO_KEY;
                n_m_status = spq_pkg::ST_OK;
            end
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [KW-1:0] left_key;
        logic                 left_valid;
        logic                 left_take;
        logic signed [KW-1:0] right_key;
        logic                 right_valid;

        if (g == 0) begin : g_head
            assign left_key   = spq_pkg::ZERO_KEY;
            assign left_valid = 1'b1;
            assign left_take  = 1'b0;
        end else begin : g_mid
            assign left_key   = cell_key[g-1];
            assign left_valid = cell_valid[g-1];
            assign left_take  = cell_take[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_key   = spq_pkg::ZERO_KEY;
            assign right_valid = 1'b0;
        end else begin : g_body
            assign right_key   = cell_key[g+1];
            assign right_valid = cell_valid[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (ctrl),
            .i_left_key    (left_key),
            .i_left_valid  (left_valid),
            .i_left_take   (left_take),
            .i_right_key   (right_key),
            .i_right_valid (right_valid),
            .o_key         (cell_key[g]),
            .o_valid       (cell_valid[g]),
            .o_take        (cell_take[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (accept) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_m_key    <= n_m_key;
            r_m_status <= n_m_status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_key;
    assign m_axis_tuser  = r_m_status;

endmodule

FILE: rtl/spq_cell.sv
// one storage cell of the sorted chain: holds one key and its valid bit
`timescale 1ns / 1ps

module spq_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  spq_pkg::t_cell_ctrl                  i_ctrl,
    input  logic signed [spq_pkg::KEY_W-1:0]     i_left_key,
    input  logic                                 i_left_valid,
    input  logic                                 i_left_take,
    input  logic signed [spq_pkg::KEY_W-1:0]     i_right_key,
    input  logic                                 i_right_valid,
    output logic signed [spq_pkg::KEY_W-1:0]     o_key,
    output logic                                 o_valid,
    output logic                                 o_take
);

    logic signed [spq_pkg::KEY_W-1:0] r_key;
    logic                             r_valid;
    logic signed [spq_pkg::KEY_W-1:0] n_key;
    logic                             n_valid;
    logic                             take;

    // an empty cell counts as larger than any key
    assign take = !r_valid || (i_ctrl.key < r_key);

    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        if (i_ctrl.ins) begin
            n_valid = r_valid | i_left_valid;
            if (take) begin
                n_key = i_left_take ? i_left_key : i_ctrl.key;
            end
        end else if (i_ctrl.del) begin
            n_key   = i_right_key;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;
    assign o_take  = take;

endmodule

FILE: rtl/spq_checker.sv
// port-level checks for the priority queue, bound to the top level
`timescale 1ns / 1ps

module spq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a held result does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // every accepted item shows a result on the next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted item gave no result");

    // empty status carries the all-ones key
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == spq_pkg::ST_EMPTY |-> m_axis_tdata == 32'hFFFF_FFFF)
        else $error("empty status with wrong key");

    // refused insert returns zero
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == spq_pkg::ST_FULL |-> m_axis_tdata == 32'd0)
        else $error("full status with nonzero key");

    // on an empty queue a peek accepted just as reset is released reports empty
    a_first_peek: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n && s_axis_tvalid && s_axis_tready
        && s_axis_tuser == spq_pkg::CMD_PEEK |=> m_axis_tuser == spq_pkg::ST_EMPTY)
        else $error("peek after reset not empty");

endmodule

bind sorted_array_priority_queue_top spq_checker u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/sorted_array_priority_queue_checker.sv
// checker for the sorted-array priority queue: predicts each result and compares
`timescale 1ns / 1ps

module sorted_array_priority_queue_checker
    import spq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // [31:0] result_value
    input  logic [1:0]  i_m_tuser,   // [1:0] status
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        t_status                 status;
    } t_result;

    // keys held in ascending order, front is the minimum
    logic signed [KEY_W-1:0] sorted_keys[$];
    t_result                 awaited_results[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        o_errors++;
    endtask

    function automatic t_result apply_command(input logic [CMD_W-1:0] cmd,
                                              input logic signed [KEY_W-1:0] key);
        t_result r;
        int      pos;
        r.key    = ZERO_KEY;
        r.status = ST_OK;
        case (cmd)
            CMD_INSERT: begin
                if (sorted_keys.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // walk down so pos ends at the first strictly greater key
                    pos = sorted_keys.size();
                    for (int i = sorted_keys.size() - 1; i >= 0; i--) begin
                        if (key < sorted_keys[i]) pos = i;
                    end
                    sorted_keys.insert(pos, key);
                end
            end
            CMD_DELETE, CMD_PEEK: begin
                if (sorted_keys.size() == 0) begin
                    r.key    = EMPTY_KEY;
                    r.status = ST_EMPTY;
                end else begin
                    r.key = sorted_keys[0];
                    if (cmd == CMD_DELETE) void'(sorted_keys.pop_front());
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_res;
        if (!i_rst_n) begin
            sorted_keys.delete();
            awaited_results.delete();
        end else begin
            // results come through the result register, so drain before taking new items
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d status %0d",
                                              $signed(i_m_tdata), i_m_tuser));
                end else begin
                    exp_res = awaited_results.pop_front();
                    if (i_m_tdata !== exp_res.key)
                        report_mismatch($sformatf("result_value %0d, expected %0d",
                                                  $signed(i_m_tdata), exp_res.key));
                    if (i_m_tuser !== exp_res.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_m_tuser, exp_res.status));
                end
            end
            if (i_s_tvalid && i_s_tready)
                awaited_results.push_back(apply_command(i_s_tuser, i_s_tdata));
        end
        o_pending = awaited_results.size();
    end

endmodule

FILE: tb/sv/sorted_array_priority_queue_top_tb.sv
// testbench top for the sorted-array priority queue: stimulus and verdict
`timescale 1ns / 1ps

module sorted_array_priority_queue_top_tb;
    import spq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int               ITEMS_PER_PHASE = 550;
    localparam int               CYCLE_LIMIT = 300000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] value
    logic [1:0]  s_axis_tuser;   // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] result_value
    logic [1:0]  m_axis_tuser;   // [1:0] status

    int   errors;
    int   pending;
    int   snd_idle;
    int   rcv_idle;
    int   cycles;
    logic snd_fire;

    sorted_array_priority_queue_top i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sorted_array_priority_queue_checker i_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tuser  (m_axis_tuser),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        snd_idle      = 0;
        rcv_idle      = 0;
        snd_fire      = 1'b0;
        cycles        = 0;
    end

    // handshake seen at the rising edge, read by the sender at the next falling edge
    always @(posedge clk) snd_fire <= s_axis_tvalid && s_axis_tready;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("sorted_array_priority_queue_top test failed");
            $finish;
        end
    end

    always @(negedge clk) begin
        if (rst_n) m_axis_tready = ($urandom_range(99) >= rcv_idle);
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = key;
        s_axis_tuser  = cmd;
        do @(negedge clk); while (!snd_fire);
    endtask

    initial begin
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        int               sent;
        int               burst_len;
        int               ins_pct;
        int               pick;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin snd_idle = 20; rcv_idle = 57; end
                1: begin snd_idle = 57; rcv_idle = 20; end
                default: begin snd_idle = 0; rcv_idle = 0; end
            endcase

            if (phase == 0) begin
                // empty queue, unused code, extreme keys, equal keys, then drain past empty
                push_item(CMD_PEEK,   32'h1234_5678);
                push_item(CMD_DELETE, 32'hdead_beef);
                push_item(CMD_UNUSED, 32'hffff_ffff);
                push_item(CMD_INSERT, 32'h7fff_ffff);
                push_item(CMD_INSERT, 32'h8000_0000);
                push_item(CMD_INSERT, 32'h0000_0000);
                push_item(CMD_INSERT, 32'hffff_ffff);
                push_item(CMD_INSERT, 32'h0000_0005);
                push_item(CMD_INSERT, 32'h0000_0005);
                push_item(CMD_PEEK,   32'hffff_ffff);
                push_item(CMD_DELETE, 32'h5555_5555);
                push_item(CMD_DELETE, 32'haaaa_aaaa);
                push_item(CMD_DELETE, 32'h0000_0000);
                push_item(CMD_PEEK,   32'h0000_0000);
                push_item(CMD_UNUSED, 32'h0000_0000);
                push_item(CMD_DELETE, 32'h7fff_ffff);
                push_item(CMD_DELETE, 32'h8000_0000);
                push_item(CMD_DELETE, 32'h0000_0001);
                push_item(CMD_DELETE, 32'h0000_0000);
                push_item(CMD_PEEK,   32'h0000_0000);
            end

            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                // bursts lean toward filling past full, draining past empty, or mixing
                burst_len = $urandom_range(80, 20);
                case ($urandom_range(2))
                    0:       ins_pct = 90;
                    1:       ins_pct = 50;
                    default: ins_pct = 12;
                endcase
                for (int n = 0; n < burst_len; n++) begin
                    pick = $urandom_range(99);
                    if (pick < 2)
                        cmd = CMD_UNUSED;
                    else if (pick < ins_pct)
                        cmd = CMD_INSERT;
                    else
                        cmd = ($urandom_range(3) == 0) ? CMD_PEEK : CMD_DELETE;
                    case ($urandom_range(5))
                        0, 1, 2: key = $urandom;
                        3, 4:    key = 32'($signed($urandom_range(16)) - 8);
                        default: begin
                            case ($urandom_range(3))
                                0:       key = 32'h8000_0000;
                                1:       key = 32'h7fff_ffff;
                                2:       key = 32'hffff_ffff;
                                default: key = 32'h0000_0000;
                            endcase
                        end
                    endcase
                    push_item(cmd, key);
                end
                sent += burst_len;
            end

            // hold the sender until every result is back
            s_axis_tvalid = 1'b0;
            while (pending != 0) @(negedge clk);
        end

        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("sorted_array_priority_queue_top test passed");
        else
            $display("sorted_array_priority_queue_top test failed");
        $finish;
    end

endmodule

FILE: sorted_array_priority_queue_top.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_array_priority_queue_top.sv
rtl/spq_checker.sv
tb/sv/sorted_array_priority_queue_checker.sv
tb/sv/sorted_array_priority_queue_top_tb.sv
